FILE: rtl/kbh_pkg.sv
// ---------------------------------------------------------------------------
// kbh_pkg
// shared types, widths and codes of the k-best max-heap
// ---------------------------------------------------------------------------
package kbh_pkg;

    localparam int MAX_K   = 16;
    localparam int DIST_W  = 32;
    localparam int ID_W    = 32;
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int CAP_W   = 5;
    localparam int FILL_W  = 5;
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam int ADDR_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // internal command codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   sample_id;
        logic [DIST_W-1:0] new_distance;
        logic [SLOT_W-1:0] read_slot;
    } cmd_t;

    // capacity zero acts as one, above the array size acts as the array size
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (int'(c) > MAX_K)
            r = CNT_W'(MAX_K);
        else
            r = CNT_W'(c);
        return r;
    endfunction

endpackage

FILE: rtl/kbh_cand_if.sv
// ---------------------------------------------------------------------------
// kbh_cand_if
// candidate word channel: valid, ready and the command fields
// ---------------------------------------------------------------------------
interface kbh_cand_if import kbh_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   sample_id;
    logic [DIST_W-1:0] new_distance;
    logic [SLOT_W-1:0] read_slot;

    modport source (
        output valid,
        output mode,
        output sample_id,
        output new_distance,
        output read_slot,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  sample_id,
        input  new_distance,
        input  read_slot,
        output ready
    );

endinterface

FILE: rtl/kbh_res_if.sv
// ---------------------------------------------------------------------------
// kbh_res_if
// result word channel: valid, ready and the status fields
// ---------------------------------------------------------------------------
interface kbh_res_if import kbh_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              accepted;
    logic [FILL_W-1:0] fill_count;
    logic              is_full;
    logic [DIST_W-1:0] worst_distance;
    logic              slot_valid;
    logic [ID_W-1:0]   slot_id;
    logic [DIST_W-1:0] slot_distance;

    modport source (
        output valid,
        output accepted,
        output fill_count,
        output is_full,
        output worst_distance,
        output slot_valid,
        output slot_id,
        output slot_distance,
        input  ready
    );

    modport sink (
        input  valid,
        input  accepted,
        input  fill_count,
        input  is_full,
        input  worst_distance,
        input  slot_valid,
        input  slot_id,
        input  slot_distance,
        output ready
    );

endinterface

FILE: rtl/kbh_ram.sv
// ---------------------------------------------------------------------------
// kbh_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module kbh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/kbh_front.sv
// ---------------------------------------------------------------------------
// kbh_front
// accepts candidate words, decodes the mode and queues commands
// ---------------------------------------------------------------------------
module kbh_front import kbh_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    kbh_cand_if.sink cand,
    output logic   cmd_valid,
    input  logic   cmd_ready,
    output cmd_t   cmd
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              dec;
    logic              push;
    logic              pop;

    // mode decode
    always_comb
    begin
        dec.sample_id    = cand.sample_id;
        dec.new_distance = cand.new_distance;
        dec.read_slot    = cand.read_slot;
        case (cand.mode)
            MODE_INSERT: dec.op = OP_INSERT;
            MODE_CLEAR:  dec.op = OP_CLEAR;
            MODE_READ:   dec.op = OP_READ;
            default:     dec.op = OP_NOP;
        endcase
    end

    assign cand.ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push       = cand.valid && cand.ready;
    assign cmd_valid  = (cnt_reg != '0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

FILE: rtl/kbh_back.sv
// ---------------------------------------------------------------------------
// kbh_back
// heap sequencer: append with sift up, root replace with sift down,
// clear, slot read, and the result word register
// ---------------------------------------------------------------------------
module kbh_back import kbh_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       capacity_we,
    input  logic [CAP_W-1:0] capacity,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    kbh_res_if.source  result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SU_RD  = 3'd1;
    localparam logic [2:0] S_SU_CMP = 3'd2;
    localparam logic [2:0] S_SD_RL  = 3'd3;
    localparam logic [2:0] S_SD_RR  = 3'd4;
    localparam logic [2:0] S_SD_CMP = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam int CHILD_W = ADDR_W + 2;
    localparam int CMP_W   = CNT_W + SLOT_W;

    logic [2:0]        state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg, capacity_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIST_W-1:0] root_reg, root_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [1:0]        op_reg, op_next;
    entry_t            new_reg, new_next;
    entry_t            lbuf_reg, lbuf_next;
    logic              r_ok_reg, r_ok_next;
    logic              acc_reg, acc_next;
    logic              sv_reg, sv_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg, out_acc_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;
    logic              out_full_reg, out_full_next;
    logic [DIST_W-1:0] out_worst_reg, out_worst_next;
    logic              out_sv_reg, out_sv_next;
    logic [ID_W-1:0]   out_sid_reg, out_sid_next;
    logic [DIST_W-1:0] out_sdist_reg, out_sdist_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;

    logic [CNT_W-1:0]   cap;
    logic               full;
    logic [ADDR_W-1:0]  pos_m1;
    logic [ADDR_W-1:0]  par;
    logic [CHILD_W-1:0] l_idx;
    logic [CHILD_W-1:0] r_idx;
    logic [CHILD_W-1:0] count_ext;
    logic               l_win;
    logic [DIST_W-1:0]  best_dist;
    logic               r_win;

    kbh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_K)
    ) u_heap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cap       = eff_cap(capacity_reg);
    assign full      = (count_reg >= cap);
    assign pos_m1    = pos_reg - 1'b1;
    assign par       = ADDR_W'(pos_m1 >> 1);
    assign l_idx     = {1'b0, pos_reg, 1'b1};
    assign r_idx     = l_idx + 1'b1;
    assign count_ext = CHILD_W'(count_reg);
    assign l_win     = (lbuf_reg.distance > new_reg.distance);
    assign best_dist = l_win ? lbuf_reg.distance : new_reg.distance;
    assign r_win     = r_ok_reg && (rd_data.distance > best_dist);
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        capacity_next  = capacity_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        new_next       = new_reg;
        lbuf_next      = lbuf_reg;
        r_ok_next      = r_ok_reg;
        acc_next       = acc_reg;
        sv_next        = sv_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_acc_next   = out_acc_reg;
        out_fill_next  = out_fill_reg;
        out_full_next  = out_full_reg;
        out_worst_next = out_worst_reg;
        out_sv_next    = out_sv_reg;
        out_sid_next   = out_sid_reg;
        out_sdist_next = out_sdist_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = new_reg;
        rd_en          = 1'b0;
        rd_addr        = par;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next      = cmd.op;
                    new_next.id  = cmd.sample_id;
                    new_next.distance = cmd.new_distance;
                    acc_next     = 1'b0;
                    sv_next      = 1'b0;
                    state_next   = S_FIN;
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (count_reg < cap)
                            begin
                                pos_next   = ADDR_W'(count_reg);
                                count_next = count_reg + 1'b1;
                                acc_next   = 1'b1;
                                state_next = S_SU_RD;
                            end
                            else if (cmd.new_distance < root_reg)
                            begin
                                pos_next   = '0;
                                acc_next   = 1'b1;
                                state_next = S_SD_RL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_READ:
                        begin
                            sv_next = (CMP_W'(cmd.read_slot) < CMP_W'(count_reg));
                            rd_en   = 1'b1;
                            rd_addr = ADDR_W'(cmd.read_slot);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // capacity write clears the heap
                if (capacity_we)
                begin
                    capacity_next = capacity;
                    count_next    = '0;
                end
            end

            S_SU_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = par;
                    state_next = S_SU_CMP;
                end
            end

            S_SU_CMP:
            begin
                wr_en = 1'b1;
                if (new_reg.distance > rd_data.distance)
                begin
                    wr_data    = rd_data;
                    pos_next   = par;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_SD_RL:
            begin
                if (l_idx < count_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = l_idx[ADDR_W-1:0];
                    state_next = S_SD_RR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
            end

            S_SD_RR:
            begin
                lbuf_next  = rd_data;
                r_ok_next  = (r_idx < count_ext);
                rd_en      = (r_idx < count_ext);
                rd_addr    = r_idx[ADDR_W-1:0];
                state_next = S_SD_CMP;
            end

            S_SD_CMP:
            begin
                wr_en = 1'b1;
                if (r_win)
                begin
                    wr_data    = rd_data;
                    pos_next   = r_idx[ADDR_W-1:0];
                    state_next = S_SD_RL;
                end
                else if (l_win)
                begin
                    wr_data    = lbuf_reg;
                    pos_next   = l_idx[ADDR_W-1:0];
                    state_next = S_SD_RL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg && (op_reg == OP_INSERT);
                    out_fill_next  = FILL_W'(count_reg);
                    out_full_next  = full;
                    out_worst_next = full ? root_reg : '1;
                    out_sv_next    = sv_reg && (op_reg == OP_READ);
                    out_sid_next   = (sv_reg && (op_reg == OP_READ)) ? rd_data.id : '0;
                    out_sdist_next = (sv_reg && (op_reg == OP_READ)) ? rd_data.distance : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow of the root distance, kept in step with every write to slot zero
    always_comb
    begin
        root_next = root_reg;
        if (wr_en && (wr_addr == '0))
        begin
            root_next = wr_data.distance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_W'(MAX_K);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg      <= root_next;
        pos_reg       <= pos_next;
        op_reg        <= op_next;
        new_reg       <= new_next;
        lbuf_reg      <= lbuf_next;
        r_ok_reg      <= r_ok_next;
        acc_reg       <= acc_next;
        sv_reg        <= sv_next;
        out_acc_reg   <= out_acc_next;
        out_fill_reg  <= out_fill_next;
        out_full_reg  <= out_full_next;
        out_worst_reg <= out_worst_next;
        out_sv_reg    <= out_sv_next;
        out_sid_reg   <= out_sid_next;
        out_sdist_reg <= out_sdist_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.accepted       = out_acc_reg;
    assign result.fill_count     = out_fill_reg;
    assign result.is_full        = out_full_reg;
    assign result.worst_distance = out_worst_reg;
    assign result.slot_valid     = out_sv_reg;
    assign result.slot_id        = out_sid_reg;
    assign result.slot_distance  = out_sdist_reg;

endmodule

FILE: rtl/k_best_max_heap.sv
// ---------------------------------------------------------------------------
// k_best_max_heap
// keeps the k smallest distances seen so far with their sample ids
// ---------------------------------------------------------------------------
// The block holds up to k entries (k from the capacity register, 1 to 16)
// in a max-heap stored in a small ram, so the root is always the worst kept
// distance. Each candidate word gives exactly one result word. Words enter
// a two-word queue and are worked one at a time by the heap sequencer; the
// single read port of the heap ram sets the pace. An append starts at the
// end slot and sifts the new entry up toward the root, a root replace puts
// it at the root and sifts it down toward the leaves, each by at most 4
// levels for k of 16; a clear, a slot read or a rejected insert moves no
// entry. A finished result sits in an output register while the queue
// keeps taking words as long as it has room. Writing capacity empties the
// heap; write it only with no word in flight. Distances tie in favor of
// the entry already held.
// ---------------------------------------------------------------------------
module k_best_max_heap import kbh_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             capacity_we,
    input  logic [CAP_W-1:0] capacity,
    kbh_cand_if.sink         cand,
    kbh_res_if.source        result
);

    // command queue between decode and the heap sequencer
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    kbh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cand      (cand),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    kbh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .result      (result)
    );

`ifndef SYNTH
    // fill count never passes the array size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (int'(result.fill_count) <= MAX_K))
        else $error("fill count above heap size");

    // worst distance saturates while not full
    a_worst_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.is_full) |-> (result.worst_distance == '1))
        else $error("worst distance not saturated");

    // invalid slot reads as zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.slot_valid) |->
            ((result.slot_id == '0) && (result.slot_distance == '0)))
        else $error("slot fields not zero");

    // a slot read never reports an accepted insert
    a_read_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.slot_valid) |-> !result.accepted)
        else $error("slot read flagged as accepted");

    // a full heap holds at least one entry
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.is_full) |-> (result.fill_count != '0))
        else $error("full with no entries");
`endif

endmodule
